FILE: sv/envelope_segment_time_allocator_core_macros.svh
// Assertion macros shared by the envelope segment time allocator RTL.
`ifndef ENVELOPE_SEGMENT_TIME_ALLOCATOR_CORE_MACROS_SVH
`define ENVELOPE_SEGMENT_TIME_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ESTA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esta assertion failed");
// Next-cycle implication, checked outside reset.
`define ESTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esta assertion failed");
`else
`define ESTA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ESTA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/esta_pkg.sv
// Package with widths, constants and types of the envelope segment time allocator.
`timescale 1ns / 1ps
package esta_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int TIME_W       = 32;
   localparam int SUM_W        = 38;
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
   localparam int SEG_ADDR_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int PROD_W       = 2 * TIME_W;
   localparam int DIV_STEPS    = TIME_W;
   localparam int STEP_W       = $clog2(DIV_STEPS);
   localparam int ENTRY_W      = TIME_W + 1;

   typedef struct packed {
      logic              flexible;
      logic [TIME_W-1:0] seg_time;
   } seg_entry_type;

endpackage

FILE: sv/esta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module esta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/envelope_segment_time_allocator_core.sv
// Envelope segment time allocator: segment store, run sums and iterative divider.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_ready     | seg_time, seg_flexible, seg_last
//  rsp     | out       | rsp_valid / rsp_ready     | actual_time, zero_divide, dropped, out_last
//  csr     | in        | csr_write_en (no wait)    | total_time
//
// A segment that is not last is accepted while the sequencer is idle. A last segment adds a setup
// state, then each stored segment passes read, multiply, divider load, 32 restoring
// divider steps and output when it needs a quotient, or read, multiply and output when its
// result is direct. The output beat waits in its register until rsp_ready, and req_ready
// stays low until the run's last beat. Reset is synchronous, active high, and clears the
// total time, sums, count, overflow flag and sequencer.
`timescale 1ns / 1ps
`include "envelope_segment_time_allocator_core_macros.svh"
module envelope_segment_time_allocator_core
   import esta_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_seg_time,
   input  logic              req_seg_flexible,
   input  logic              req_seg_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [TIME_W-1:0] rsp_actual_time,
   output logic              rsp_zero_divide,
   output logic              rsp_dropped,
   output logic              rsp_out_last,
   input  logic              csr_write_en,
   input  logic [TIME_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] total_time_ff, total_time_in;
   logic [SUM_W-1:0]  fixed_sum_ff, fixed_sum_in;
   logic [SUM_W-1:0]  share_sum_ff, share_sum_in;
   logic [CNT_W-1:0]  seg_count_ff, seg_count_in;
   logic              overflow_ff, overflow_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              scale_ff, scale_in;
   logic              zdiv_ff, zdiv_in;
   logic              share_zero_ff, share_zero_in;
   logic [TIME_W-1:0] mul_op_ff, mul_op_in;
   logic [SUM_W-1:0]  div_ff, div_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0] num_ff, num_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] result_ff, result_in;

   logic              req_accept;
   logic              has_room;
   logic              store_en;
   logic              is_last_out;
   seg_entry_type     wr_entry;
   seg_entry_type     rd_entry;
   logic [ENTRY_W-1:0] rd_raw;
   logic [SUM_W-1:0]  total_ext;
   logic [SUM_W-1:0]  seg_ext;
   logic [SUM_W:0]    rem_sh;
   logic [SUM_W+1:0]  diff;
   logic              quo_bit;
   logic [TIME_W-1:0] num_next;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign has_room    = (seg_count_ff < CNT_W'(MAX_SEGMENTS));
   assign store_en    = req_accept && has_room;
   assign is_last_out = ((idx_ff + CNT_W'(1)) == seg_count_ff);
   assign total_ext   = SUM_W'(total_time_ff);
   assign seg_ext     = SUM_W'(req_seg_time);

   assign wr_entry.flexible = req_seg_flexible;
   assign wr_entry.seg_time = req_seg_time;
   assign rd_entry          = seg_entry_type'(rd_raw);

   esta_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_SEGMENTS)
   ) u_seg_ram (
      .clock  (clock),
      .wr_en  (store_en),
      .wr_addr(seg_count_ff[SEG_ADDR_W-1:0]),
      .wr_data(wr_entry),
      .rd_en  (state_ff == ST_READ),
      .rd_addr(idx_ff[SEG_ADDR_W-1:0]),
      .rd_data(rd_raw)
   );

   // One restoring step: bring down the next numerator bit and try the subtract.
   assign rem_sh   = {rem_ff, num_ff[TIME_W-1]};
   assign diff     = {1'b0, rem_sh} - {2'b00, div_ff};
   assign quo_bit  = !diff[SUM_W+1];
   assign num_next = {num_ff[TIME_W-2:0], quo_bit};

   always_comb begin
      state_in      = state_ff;
      total_time_in = csr_write_en ? csr_write_data : total_time_ff;
      fixed_sum_in  = fixed_sum_ff;
      share_sum_in  = share_sum_ff;
      seg_count_in  = seg_count_ff;
      overflow_in   = overflow_ff;
      idx_in        = idx_ff;
      scale_in      = scale_ff;
      zdiv_in       = zdiv_ff;
      share_zero_in = share_zero_ff;
      mul_op_in     = mul_op_ff;
      div_in        = div_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      step_in       = step_ff;
      result_in     = result_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (has_room) begin
                  seg_count_in = seg_count_ff + CNT_W'(1);
                  if (req_seg_flexible) begin
                     share_sum_in = share_sum_ff + seg_ext;
                  end else begin
                     fixed_sum_in = fixed_sum_ff + seg_ext;
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_seg_last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            share_zero_in = (share_sum_ff == '0);
            scale_in      = (fixed_sum_ff > total_ext) ||
                            ((fixed_sum_ff < total_ext) && (share_sum_ff == '0));
            zdiv_in       = scale_in && (fixed_sum_ff == '0);
            // Outside scaling mode the fixed sum never exceeds the total.
            mul_op_in     = scale_in ? total_time_ff
                                     : total_time_ff - fixed_sum_ff[TIME_W-1:0];
            div_in        = scale_in ? fixed_sum_ff : share_sum_ff;
            idx_in        = '0;
            state_in      = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = PROD_W'(rd_entry.seg_time) * PROD_W'(mul_op_ff);
            if (zdiv_ff) begin
               result_in = '0;
               state_in  = ST_OUT;
            end else if (scale_ff) begin
               if (rd_entry.flexible) begin
                  result_in = '0;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_PREP;
               end
            end else if (rd_entry.flexible) begin
               if (share_zero_ff) begin
                  result_in = '0;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_PREP;
               end
            end else begin
               result_in = rd_entry.seg_time;
               state_in  = ST_OUT;
            end
         end
         ST_PREP: begin
            // The quotient fits in 32 bits, so the upper product half is below the divisor.
            rem_in   = SUM_W'(prod_ff[PROD_W-1:TIME_W]);
            num_in   = prod_ff[TIME_W-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = quo_bit ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            num_in  = num_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               result_in = num_next;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (is_last_out) begin
                  fixed_sum_in = '0;
                  share_sum_in = '0;
                  seg_count_in = '0;
                  overflow_in  = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_time_ff <= '0;
         fixed_sum_ff  <= '0;
         share_sum_ff  <= '0;
         seg_count_ff  <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_time_ff <= total_time_in;
         fixed_sum_ff  <= fixed_sum_in;
         share_sum_ff  <= share_sum_in;
         seg_count_ff  <= seg_count_in;
         overflow_ff   <= overflow_in;
      end
      idx_ff        <= idx_in;
      scale_ff      <= scale_in;
      zdiv_ff       <= zdiv_in;
      share_zero_ff <= share_zero_in;
      mul_op_ff     <= mul_op_in;
      div_ff        <= div_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      step_ff       <= step_in;
      result_ff     <= result_in;
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_actual_time = result_ff;
   assign rsp_zero_divide = zdiv_ff;
   assign rsp_dropped     = overflow_ff;
   assign rsp_out_last    = is_last_out;

   `ESTA_ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `ESTA_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1,
                     seg_count_ff <= CNT_W'(MAX_SEGMENTS))
   `ESTA_ASSERT_IMPL(a_rem_below_div, clock, reset, state_ff == ST_DIV, rem_ff < div_ff)
   `ESTA_ASSERT_IMPL(a_zdiv_zero, clock, reset, rsp_valid && rsp_zero_divide,
                     rsp_actual_time == '0)
   `ESTA_ASSERT_NEXT(a_run_clears, clock, reset, rsp_valid && rsp_ready && rsp_out_last,
                     req_ready && (seg_count_ff == '0) && !overflow_ff)

endmodule
